/* rtl/cbe_pkg.sv */
package cbe_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int BISECT_ROUNDS = 8;
  localparam int PROG_W        = FRAC_BITS + 1;
  localparam int XC_W          = FRAC_BITS + 1;
  localparam int YC_W          = FRAC_BITS + 3;
  localparam int CALC_W        = FRAC_BITS + 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = YC_W;

  localparam logic [PROG_W-1:0] ONE_P  = PROG_W'(1) << FRAC_BITS;
  localparam logic [PROG_W-1:0] HALF_P = PROG_W'(1) << (FRAC_BITS - 1);

  typedef logic [PROG_W-1:0]        prog_t;
  typedef logic signed [CALC_W-1:0] calc_t;
  typedef logic [XC_W-1:0]          xc_t;
  typedef logic signed [YC_W-1:0]   yc_t;

  localparam calc_t ONE_C     = calc_t'(1) <<< FRAC_BITS;
  localparam calc_t SAT_LO_C  = -ONE_C;
  localparam calc_t SAT_HI_C  = ONE_C <<< 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X1 = 2'd0,
    CFG_Y1 = 2'd1,
    CFG_X2 = 2'd2,
    CFG_Y2 = 2'd3
  } cfg_idx_e;

  // sideband that travels with a bisection item
  typedef struct packed {
    prog_t t;
    prog_t lo;
    prog_t hi;
    prog_t u;
  } side_t;

  function automatic calc_t ext_u(prog_t v);
    return calc_t'({{(CALC_W-PROG_W){1'b0}}, v});
  endfunction

  // product shifted arithmetically right, i.e. floor
  function automatic calc_t fmul(calc_t a, calc_t b);
    logic signed [2*CALC_W-1:0] p;
    p = a * b;
    return calc_t'(p >>> FRAC_BITS);
  endfunction

  function automatic side_t next_side(side_t s, calc_t x);
    side_t n;
    n = s;
    if (x < ext_u(s.t)) begin
      n.lo = s.u;
    end else begin
      n.hi = s.u;
    end
    n.u = n.lo + ((n.hi - n.lo) >> 1);
    return n;
  endfunction

endpackage

/* rtl/cubic_bezier_easing.sv */
// Cubic bezier easing: one progress beat in, one eased beat out, a new beat every clock
// while the output is not stalled. Each bisection round and the final y evaluation
// is a three-stage de casteljau multiplier pipeline, then an output register. The whole
// pipe freezes while the output beat waits. Control points are taken live from the config
// registers, so write them only while the block is idle.
module cubic_bezier_easing (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cbe_pkg::PROG_W-1:0]          progress_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cbe_pkg::YC_W-1:0]     eased_o,
  input  logic                                cfg_we_i,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cbe_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int R = cbe_pkg::BISECT_ROUNDS;

  cbe_pkg::xc_t x1_q, x2_q;
  cbe_pkg::yc_t y1_q, y2_q;
  logic en;
  logic out_vld_q;
  logic signed [cbe_pkg::YC_W-1:0] eased_q;
  cbe_pkg::calc_t eased_d;

  logic           vi [0:R];
  cbe_pkg::side_t si [0:R];
  logic           vo [0:R];
  cbe_pkg::side_t so [0:R];
  cbe_pkg::calc_t ro [0:R];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= cbe_pkg::XC_W'(16384);
      y1_q <= '0;
      x2_q <= cbe_pkg::XC_W'(49152);
      y2_q <= cbe_pkg::YC_W'(65536);
    end else if (cfg_we_i) begin
      case (cbe_pkg::cfg_idx_e'(cfg_idx_i))
        cbe_pkg::CFG_X1: x1_q <= cfg_data_i[cbe_pkg::XC_W-1:0];
        cbe_pkg::CFG_Y1: y1_q <= cfg_data_i;
        cbe_pkg::CFG_X2: x2_q <= cfg_data_i[cbe_pkg::XC_W-1:0];
        cbe_pkg::CFG_Y2: y2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign vi[0]    = in_valid_i;
  assign si[0].t  = progress_i;
  assign si[0].lo = '0;
  assign si[0].hi = cbe_pkg::ONE_P;
  assign si[0].u  = cbe_pkg::HALF_P;

  for (genvar g = 0; g <= R; g++) begin : g_round
    cbe_pkg::calc_t c1, c2;
    if (g < R) begin : g_x
      assign c1 = cbe_pkg::calc_t'({{(cbe_pkg::CALC_W-cbe_pkg::XC_W){1'b0}}, x1_q});
      assign c2 = cbe_pkg::calc_t'({{(cbe_pkg::CALC_W-cbe_pkg::XC_W){1'b0}}, x2_q});
    end else begin : g_y
      assign c1 = cbe_pkg::calc_t'(y1_q);
      assign c2 = cbe_pkg::calc_t'(y2_q);
    end

    cbe_bez u_bez (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .c1_i   (c1),
      .c2_i   (c2),
      .vld_i  (vi[g]),
      .side_i (si[g]),
      .vld_o  (vo[g]),
      .side_o (so[g]),
      .res_o  (ro[g])
    );

    if (g < R) begin : g_next
      assign vi[g+1] = vo[g];
      assign si[g+1] = cbe_pkg::next_side(so[g], ro[g]);
    end
  end

  always_comb begin
    eased_d = ro[R];
    if (eased_d < cbe_pkg::SAT_LO_C) eased_d = cbe_pkg::SAT_LO_C;
    if (eased_d > cbe_pkg::SAT_HI_C) eased_d = cbe_pkg::SAT_HI_C;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vo[R];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eased_q <= eased_d[cbe_pkg::YC_W-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign eased_o     = eased_q;

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (eased_o >= cbe_pkg::YC_W'(cbe_pkg::SAT_LO_C)) &&
                    (eased_o <= cbe_pkg::YC_W'(cbe_pkg::SAT_HI_C)))
    else $error("eased beat outside saturation range");

  a_final_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vi[R] |-> (si[R].hi - si[R].lo) == (cbe_pkg::ONE_P >> R))
    else $error("final interval has wrong width");

  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vi[R] |-> (si[R].u > si[R].lo) && (si[R].u < si[R].hi))
    else $error("final parameter outside its interval");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vo[R]) && $stable(so[R]))
    else $error("pipeline moved during stall");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting output beat");

endmodule

/* rtl/cbe_bez.sv */
module cbe_bez (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  cbe_pkg::calc_t  c1_i,
  input  cbe_pkg::calc_t  c2_i,
  input  logic            vld_i,
  input  cbe_pkg::side_t  side_i,
  output logic            vld_o,
  output cbe_pkg::side_t  side_o,
  output cbe_pkg::calc_t  res_o
);

  logic v1_q, v2_q, v3_q;
  cbe_pkg::side_t s1_q, s2_q, s3_q;
  cbe_pkg::calc_t q0_q, q1_q, q2_q, r0_q, r1_q, res_q;
  cbe_pkg::calc_t u0, u1, u2;
  cbe_pkg::calc_t q0_d, q1_d, q2_d, r0_d, r1_d, res_d;

  assign u0 = cbe_pkg::ext_u(side_i.u);
  assign u1 = cbe_pkg::ext_u(s1_q.u);
  assign u2 = cbe_pkg::ext_u(s2_q.u);

  // de casteljau, one level per stage
  assign q0_d  = cbe_pkg::fmul(u0, c1_i);
  assign q1_d  = c1_i + cbe_pkg::fmul(u0, c2_i - c1_i);
  assign q2_d  = c2_i + cbe_pkg::fmul(u0, cbe_pkg::ONE_C - c2_i);
  assign r0_d  = q0_q + cbe_pkg::fmul(u1, q1_q - q0_q);
  assign r1_d  = q1_q + cbe_pkg::fmul(u1, q2_q - q1_q);
  assign res_d = r0_q + cbe_pkg::fmul(u2, r1_q - r0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= side_i;
      q0_q  <= q0_d;
      q1_q  <= q1_d;
      q2_q  <= q2_d;
      s2_q  <= s1_q;
      r0_q  <= r0_d;
      r1_q  <= r1_d;
      s3_q  <= s2_q;
      res_q <= res_d;
    end
  end

  assign vld_o  = v3_q;
  assign side_o = s3_q;
  assign res_o  = res_q;

endmodule
